>>> rtl/gsu_pkg.sv
// Package for the GCD search unit: payload types, the subtractor control struct
// and the fixed field and digit widths.
// No dependencies.
package gsu_pkg;

    // Width of the operand and divisor fields on the ports.
    localparam int DATA_W = 32;

    // Width of one digit handled by the serial subtractor in each cycle.
    localparam int DIGIT_W = 8;

    // One input transaction.
    typedef struct packed {
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [DATA_W-1:0] divisor;
        logic              found;
    } t_out_item;

    // Control from the sequencer to the digit-serial subtractor.
    typedef struct packed {
        logic clear;
        logic step;
    } t_sub_ctrl;

endpackage

>>> rtl/gsu_digit_sub.sv
// Digit-serial subtractor: forms a-b and b-a LSB first, one digit per cycle
// while step is set, and keeps the running borrows. Depends on gsu_pkg.
module gsu_digit_sub (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gsu_pkg::t_sub_ctrl         i_ctrl,
    input  logic [gsu_pkg::DIGIT_W-1:0] i_a_dig,
    input  logic [gsu_pkg::DIGIT_W-1:0] i_b_dig,
    output logic [gsu_pkg::DIGIT_W-1:0] o_ab_dig,
    output logic [gsu_pkg::DIGIT_W-1:0] o_ba_dig,
    output logic                       o_a_lt_b
);

    localparam int D = gsu_pkg::DIGIT_W;

    logic         r_bor_ab;
    logic         r_bor_ba;
    logic [D:0]   w_ab;
    logic [D:0]   w_ba;

    // One digit of each difference; the top bit is the borrow out.
    assign w_ab = {1'b0, i_a_dig} - {1'b0, i_b_dig} - (D+1)'(r_bor_ab);
    assign w_ba = {1'b0, i_b_dig} - {1'b0, i_a_dig} - (D+1)'(r_bor_ba);

    assign o_ab_dig = w_ab[D-1:0];
    assign o_ba_dig = w_ba[D-1:0];

    // After the last digit, the borrow of a-b says that a is below b.
    assign o_a_lt_b = r_bor_ab;

    // Borrow registers, cleared at the start of each subtraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_bor_ab <= 1'b0;
            r_bor_ba <= 1'b0;
        end else if (i_ctrl.step) begin
            r_bor_ab <= w_ab[D];
            r_bor_ba <= w_ba[D];
        end
    end

endmodule

>>> rtl/gsu_core.sv
// Binary GCD sequencer with operand shift registers and the digit-serial
// subtractor. Depends on gsu_pkg and gsu_digit_sub.
module gsu_core #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  gsu_pkg::t_in_item  i_operands,
    input  logic               i_take,
    output logic               o_idle,
    output logic               o_done,
    output gsu_pkg::t_out_item o_result
);

    localparam int DW   = gsu_pkg::DATA_W;
    localparam int D    = gsu_pkg::DIGIT_W;
    localparam int EW   = (OPERAND_WIDTH < DW) ? OPERAND_WIDTH : DW;
    localparam int NDIG = (EW + D - 1) / D;
    localparam int RW   = NDIG * D;
    localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int KW   = $clog2(EW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIP,
        S_EVEN,
        S_SUB,
        S_APPLY,
        S_SHL,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [RW-1:0]     r_a, n_a;
    logic [RW-1:0]     r_b, n_b;
    logic [RW-1:0]     r_da, n_da;
    logic [RW-1:0]     r_db, n_db;
    logic [KW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_found, n_found;

    gsu_pkg::t_sub_ctrl w_sub_ctrl;
    logic [D-1:0]      w_ab_dig;
    logic [D-1:0]      w_ba_dig;
    logic              w_a_lt_b;
    logic [EW-1:0]     w_in_a;
    logic [EW-1:0]     w_in_b;

    // Only the low operand bits take part.
    assign w_in_a = i_operands.operand_a[EW-1:0];
    assign w_in_b = i_operands.operand_b[EW-1:0];

    gsu_digit_sub u_sub (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_sub_ctrl),
        .i_a_dig  (r_a[D-1:0]),
        .i_b_dig  (r_b[D-1:0]),
        .o_ab_dig (w_ab_dig),
        .o_ba_dig (w_ba_dig),
        .o_a_lt_b (w_a_lt_b)
    );

    // Next-state logic of the binary GCD loop.
    always_comb begin
        n_state    = r_state;
        n_a        = r_a;
        n_b        = r_b;
        n_da       = r_da;
        n_db       = r_db;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_found    = r_found;
        w_sub_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_a = RW'(w_in_a);
                    n_b = RW'(w_in_b);
                    n_k = '0;
                    if (w_in_a == '0 || w_in_b == '0) begin
                        // A zero operand has no divisor to report.
                        n_a     = '0;
                        n_found = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_found = 1'b1;
                        n_state = S_STRIP;
                    end
                end
            end
            S_STRIP: begin
                // Pull out the common powers of two.
                if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_EVEN;
                end
            end
            S_EVEN: begin
                if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a == r_b) begin
                    n_state = (r_k == '0) ? S_DONE : S_SHL;
                end else begin
                    w_sub_ctrl.clear = 1'b1;
                    n_cnt            = '0;
                    n_state          = S_SUB;
                end
            end
            S_SUB: begin
                // Rotate both operands one digit and shift in the difference digits.
                w_sub_ctrl.step = 1'b1;
                n_a  = (r_a >> D) | (RW'(r_a[D-1:0]) << (RW - D));
                n_b  = (r_b >> D) | (RW'(r_b[D-1:0]) << (RW - D));
                n_da = (r_da >> D) | (RW'(w_ab_dig) << (RW - D));
                n_db = (r_db >> D) | (RW'(w_ba_dig) << (RW - D));
                if (r_cnt == CW'(NDIG - 1)) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_APPLY: begin
                // The larger operand takes the difference.
                if (w_a_lt_b) begin
                    n_b = r_db;
                end else begin
                    n_a = r_da;
                end
                n_state = S_EVEN;
            end
            S_SHL: begin
                // Restore the common powers of two.
                n_a = r_a << 1;
                n_k = r_k - 1'b1;
                if (r_k == KW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_da    <= n_da;
        r_db    <= n_db;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_found <= n_found;
    end

    assign o_idle           = (r_state == S_IDLE);
    assign o_done           = (r_state == S_DONE);
    assign o_result.divisor = DW'(r_a);
    assign o_result.found   = r_found;

endmodule

>>> rtl/gcd_search_unit.sv
// Top level of the GCD search unit: input handshake, GCD core and output register.
// Depends on gsu_pkg and gsu_core.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  input   | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  output  | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// One transaction at a time passes through the binary GCD loop. Halving steps run
// in S_STRIP and S_EVEN; an odd-odd subtraction passes S_EVEN, S_SUB once per digit
// and S_APPLY, with NDIG 8-bit digits per operand (4 at 32 bits). Equal odd operands
// go through S_STRIP and S_EVEN to S_DONE, a zero operand from S_IDLE to S_DONE, and
// the input is free again once the result has moved into the output register.
// Reset is synchronous and active low and empties the core and the output register.
// The next transaction is taken while a finished result waits in the output register;
// the input stalls while the core works or holds a result that cannot move on.
module gcd_search_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gsu_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gsu_pkg::t_out_item o_out_data
);

    logic               w_core_idle;
    logic               w_core_done;
    logic               w_out_free;
    gsu_pkg::t_out_item w_core_result;
    logic               r_out_valid;
    gsu_pkg::t_out_item r_out_data;

    // The output register can take a result when empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;

    gsu_core #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && w_core_idle),
        .i_operands (i_in_data),
        .i_take     (w_out_free),
        .o_idle     (w_core_idle),
        .o_done     (w_core_done),
        .o_result   (w_core_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_core_done && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_core_done && w_out_free) begin
            r_out_data <= w_core_result;
        end
    end

    assign o_in_stall  = !w_core_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/gsu_checker.sv
// Port-level checker for the GCD search unit and its bind to the top level.
// Depends on gsu_pkg.
module gsu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input gsu_pkg::t_out_item i_out_data
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // A result without a divisor carries zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.found |-> i_out_data.divisor == '0)
        else $error("nonzero divisor with found clear");

    // A found divisor is never zero.
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.found |-> i_out_data.divisor != '0)
        else $error("zero divisor with found set");

    // The unit works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("second transaction taken while busy");

endmodule

bind gcd_search_unit gsu_checker u_gsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
